FILE: rtl/ifd_pkg.sv
// Package: shared types, constants and control structs for the fall/impact detector.
package ifd_pkg;

   localparam int WindowDepth    = 3;
   localparam int SustainedCount = 2;
   localparam int SlotWidth      = $clog2(WindowDepth);
   localparam int CountWidth     = $clog2(WindowDepth + 1);

   localparam logic [15:0] OneG      = 16'd1024;
   localparam logic [31:0] MinFallMs = 32'd100;
   localparam logic [31:0] HoldMs    = 32'd200;
   localparam logic [31:0] ZeroDtMs  = 32'd10;
   localparam logic [25:0] JerkMax   = 26'h3FFFFFF;
   // ceil(2^33 / 3): exact divide by three for sums below 2^32
   localparam logic [31:0] RecipThree = 32'hAAAA_AAAB;

   typedef enum logic [2:0] {
      MODE_NORMAL    = 3'd0,
      MODE_FREEFALL  = 3'd1,
      MODE_IMPACT    = 3'd2,
      MODE_POST      = 3'd3,
      MODE_INJURY    = 3'd4,
      MODE_RECOVERED = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_FALL   = 2'd1,
      EV_DIRECT = 2'd2,
      EV_HEAVY  = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      REG_SEVERE     = 3'd0,
      REG_MEDIUM     = 3'd1,
      REG_FREEFALL   = 3'd2,
      REG_JERK       = 3'd3,
      REG_ROTATION   = 3'd4,
      REG_STILL_ROT  = 3'd5,
      REG_MAX_FALL   = 3'd6,
      REG_STILL_TIME = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_LOAD  = 3'd1,
      ST_DIV   = 3'd2,
      ST_NEXT  = 3'd3,
      ST_MEAN  = 3'd4,
      ST_DECIDE = 3'd5,
      ST_OUT   = 3'd6
   } ctrl_state_type;

   typedef struct packed {
      logic       capture;
      logic       div_start;
      logic [1:0] term_sel;
      logic       add_term;
      logic       mean_start;
      logic       decide;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_busy;
   } status_type;

endpackage

FILE: rtl/ifd_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
interface ifd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] accel_x;
   logic [15:0] accel_y;
   logic [15:0] accel_z;
   logic [15:0] accel_magnitude;
   logic [15:0] gyro_magnitude;
   logic [31:0] time_ms;
   modport source (output valid, accel_x, accel_y, accel_z, accel_magnitude,
                   gyro_magnitude, time_ms, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, accel_magnitude,
                 gyro_magnitude, time_ms, output ready);
endinterface

interface ifd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [2:0]  mode;
   logic [1:0]  latched_event;
   logic [25:0] jerk;
   logic        lying_flat;
   logic        is_still;
   modport source (output valid, event_res, mode, latched_event, jerk, lying_flat,
                   is_still, input ready);
   modport sink (input valid, event_res, mode, latched_event, jerk, lying_flat,
                 is_still, output ready);
endinterface

interface ifd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [25:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ifd_ctrl.sv
// Controller: sequences capture, three serial divisions, the mean and the mode update.
module ifd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ifd_pkg::status_type     status,
   output ifd_pkg::cmd_type        cmd
);

   ifd_pkg::ctrl_state_type state_ff, state_in;
   logic [1:0] term_ff, term_in;

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      unique case (state_ff)
         ifd_pkg::ST_IDLE: if (req_valid) state_in = ifd_pkg::ST_LOAD;
         ifd_pkg::ST_LOAD: begin
            term_in  = 2'd0;
            state_in = ifd_pkg::ST_DIV;
         end
         ifd_pkg::ST_DIV: if (status.div_done) state_in = ifd_pkg::ST_NEXT;
         ifd_pkg::ST_NEXT: begin
            if (term_ff == 2'd2) begin
               state_in = ifd_pkg::ST_MEAN;
            end else begin
               term_in  = term_ff + 2'd1;
               state_in = ifd_pkg::ST_DIV;
            end
         end
         ifd_pkg::ST_MEAN: state_in = ifd_pkg::ST_DECIDE;
         // hold until the previous word has left the output register
         ifd_pkg::ST_DECIDE: if (!status.out_busy) state_in = ifd_pkg::ST_OUT;
         ifd_pkg::ST_OUT: if (!status.out_busy) state_in = ifd_pkg::ST_IDLE;
         default: state_in = ifd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      cmd.term_sel = term_ff;
      unique case (state_ff)
         ifd_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ifd_pkg::ST_LOAD: begin
            cmd.div_start = 1'b1;
            cmd.term_sel  = 2'd0;
         end
         ifd_pkg::ST_DIV: cmd.add_term = status.div_done;
         ifd_pkg::ST_NEXT: begin
            cmd.div_start  = (term_ff != 2'd2);
            cmd.term_sel   = term_ff + 2'd1;
         end
         ifd_pkg::ST_MEAN: cmd.mean_start = 1'b1;
         ifd_pkg::ST_DECIDE: cmd.decide = !status.out_busy;
         ifd_pkg::ST_OUT: cmd.out_load = !status.out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ifd_pkg::ST_IDLE;
         term_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ifd_pkg::ST_IDLE)
      else $error("ready outside idle");
   a_capture_load: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ifd_pkg::ST_LOAD)
      else $error("capture did not start work");
   a_term_range: assert property (@(posedge clock) disable iff (reset)
      term_ff != 2'd3)
      else $error("term index out of range");
`endif

endmodule

FILE: rtl/ifd_datapath.sv
// Datapath: sample capture, history, serial divider, thresholds, mode state and output word.
module ifd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   ifd_req_if.sink              req,
   ifd_rsp_if.source            rsp,
   ifd_csr_if.sink              csr,
   input  ifd_pkg::cmd_type     cmd,
   output ifd_pkg::status_type  status
);

   localparam int SW = ifd_pkg::SlotWidth;

   // configuration
   logic [15:0] severe_ff, medium_ff, freefall_ff, rotation_ff, still_rot_ff;
   logic [15:0] max_fall_ff, still_time_ff;
   logic [25:0] jerk_level_ff;

   // captured sample
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic [15:0] mag_ff, gyro_ff;
   logic [31:0] now_ff;

   // state
   ifd_pkg::mode_type  mode_ff;
   ifd_pkg::event_type latched_ff;
   logic [31:0] fall_start_ff, hit_start_ff, still_start_ff;
   logic [15:0] pmag_ff [3];
   logic [31:0] ptime_ff [3];
   logic [15:0] win_ff [ifd_pkg::WindowDepth];
   logic [SW-1:0] slot_ff;

   // divider: 38-bit dividend, 32-bit divisor, restoring, one bit per cycle
   logic [37:0] quot_ff;
   logic [31:0] rem_ff, dvs_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [27:0] sum_ff;
   logic [25:0] jerk_ff;

   // output register
   logic        ovalid_ff;
   logic [1:0]  oev_ff, olat_ff;
   logic [2:0]  omode_ff;
   logic [25:0] ojerk_ff;
   logic        ohor_ff, ostill_ff;

   assign csr.ready = 1'b1;
   assign req.ready = 1'b0 | 1'b0; // driven by the top level
   assign status.div_done = done_ff;
   assign status.out_busy = ovalid_ff && !rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         severe_ff     <= 16'd8192;
         medium_ff     <= 16'd4096;
         freefall_ff   <= 16'd307;
         jerk_level_ff <= 26'd66560;
         rotation_ff   <= 16'd3200;
         still_rot_ff  <= 16'd320;
         max_fall_ff   <= 16'd500;
         still_time_ff <= 16'd2000;
      end else if (csr.valid) begin
         unique case (ifd_pkg::reg_index_type'(csr.index))
            ifd_pkg::REG_SEVERE:     severe_ff     <= csr.data[15:0];
            ifd_pkg::REG_MEDIUM:     medium_ff     <= csr.data[15:0];
            ifd_pkg::REG_FREEFALL:   freefall_ff   <= csr.data[15:0];
            ifd_pkg::REG_JERK:       jerk_level_ff <= csr.data;
            ifd_pkg::REG_ROTATION:   rotation_ff   <= csr.data[15:0];
            ifd_pkg::REG_STILL_ROT:  still_rot_ff  <= csr.data[15:0];
            ifd_pkg::REG_MAX_FALL:   max_fall_ff   <= csr.data[15:0];
            ifd_pkg::REG_STILL_TIME: still_time_ff <= csr.data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff   <= req.accel_x;
         ay_ff   <= req.accel_y;
         az_ff   <= req.accel_z;
         mag_ff  <= req.accel_magnitude;
         gyro_ff <= req.gyro_magnitude;
         now_ff  <= req.time_ms;
      end
   end

   // operand select for the selected jerk term
   logic [15:0] mag_new, mag_old, dmag;
   logic [31:0] t_new, t_old, dt;
   always_comb begin
      case (cmd.term_sel)
         2'd0: begin
            mag_new = mag_ff;     mag_old = pmag_ff[0];
            t_new   = now_ff;     t_old   = ptime_ff[0];
         end
         2'd1: begin
            mag_new = pmag_ff[0]; mag_old = pmag_ff[1];
            t_new   = ptime_ff[0]; t_old  = ptime_ff[1];
         end
         default: begin
            mag_new = pmag_ff[1]; mag_old = pmag_ff[2];
            t_new   = ptime_ff[1]; t_old  = ptime_ff[2];
         end
      endcase
      dmag = (mag_new > mag_old) ? mag_new - mag_old : mag_old - mag_new;
      dt   = t_new - t_old;
      if (dt == 32'd0) dt = ifd_pkg::ZeroDtMs;
   end

   logic [37:0] dvd;
   assign dvd = 38'(dmag) * 38'd1000;

   logic [32:0] trial;
   assign trial = {rem_ff, quot_ff[37]} - {1'b0, dvs_ff};

   // divide the term sum by three through the reciprocal, keep the top bits
   logic [59:0] mean_prod;
   logic [26:0] mean_q;
   assign mean_prod = 60'(sum_ff) * 60'(ifd_pkg::RecipThree);
   assign mean_q    = mean_prod[59:33];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.div_start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quot_ff <= dvd;
         dvs_ff  <= dt;
         rem_ff  <= '0;
         cnt_ff  <= 6'd38;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 6'd1;
         if (!trial[32]) begin
            rem_ff  <= trial[31:0];
            quot_ff <= {quot_ff[36:0], 1'b1};
         end else begin
            rem_ff  <= {rem_ff[30:0], quot_ff[37]};
            quot_ff <= {quot_ff[36:0], 1'b0};
         end
      end
      if (cmd.capture) sum_ff <= '0;
      else if (cmd.add_term) sum_ff <= sum_ff + 28'(quot_ff);
      if (cmd.mean_start) begin
         jerk_ff <= (mean_q > 27'(ifd_pkg::JerkMax)) ? ifd_pkg::JerkMax : mean_q[25:0];
      end
   end

   // flags
   logic [31:0] xsq, ysq;
   logic [32:0] hsq;
   logic [37:0] hsq25;
   logic [15:0] az_abs, dev;
   logic [18:0] dev5;
   logic horiz, still, hard, severe;
   logic [ifd_pkg::CountWidth-1:0] wcount;

   always_comb begin
      xsq   = 32'($signed(ax_ff) * $signed(ax_ff));
      ysq   = 32'($signed(ay_ff) * $signed(ay_ff));
      hsq   = {1'b0, xsq} + {1'b0, ysq};
      hsq25 = 38'(hsq) * 38'd25;
      az_abs = az_ff[15] ? 16'(-az_ff) : az_ff;
      horiz = (hsq25 > 38'd12845056) && (az_abs < 16'd512);
      dev   = (mag_ff > ifd_pkg::OneG) ? mag_ff - ifd_pkg::OneG : ifd_pkg::OneG - mag_ff;
      dev5  = 19'(dev) * 19'd5;
      still = (dev5 < 19'd1536) && (gyro_ff < still_rot_ff);
      hard  = (mag_ff > medium_ff) && (jerk_ff > jerk_level_ff);
      severe = mag_ff > severe_ff;
      wcount = '0;
      for (int i = 0; i < ifd_pkg::WindowDepth; i++) begin
         // current sample occupies its slot already
         if (((SW'(i) == slot_ff) ? mag_ff : win_ff[i]) > medium_ff)
            wcount = wcount + 1'b1;
      end
   end

   logic [31:0] fdur, hdur, sdur;
   assign fdur = now_ff - fall_start_ff;
   assign hdur = now_ff - hit_start_ff;
   assign sdur = now_ff - still_start_ff;

   ifd_pkg::mode_type  mode_in;
   ifd_pkg::event_type lat_in, ev_in;
   logic set_fall, set_hit, set_still;

   always_comb begin
      mode_in = mode_ff;
      lat_in  = latched_ff;
      ev_in   = ifd_pkg::EV_NONE;
      set_fall = 1'b0;
      set_hit  = 1'b0;
      set_still = 1'b0;
      if (severe) begin
         mode_in = ifd_pkg::MODE_INJURY;
         lat_in  = ifd_pkg::EV_HEAVY;
         ev_in   = ifd_pkg::EV_HEAVY;
      end else begin
         case (mode_ff)
            ifd_pkg::MODE_NORMAL: begin
               if (mag_ff < freefall_ff) begin
                  set_fall = 1'b1;
                  lat_in   = ifd_pkg::EV_FALL;
                  mode_in  = ifd_pkg::MODE_FREEFALL;
               end else if (hard) begin
                  if (wcount >= ifd_pkg::CountWidth'(ifd_pkg::SustainedCount)) begin
                     set_hit = 1'b1;
                     lat_in  = ifd_pkg::EV_DIRECT;
                     mode_in = ifd_pkg::MODE_IMPACT;
                  end
               end else if (gyro_ff > rotation_ff && mag_ff > medium_ff) begin
                  set_hit = 1'b1;
                  lat_in  = ifd_pkg::EV_DIRECT;
                  mode_in = ifd_pkg::MODE_IMPACT;
               end
            end
            ifd_pkg::MODE_FREEFALL: begin
               if (hard) begin
                  if (fdur >= ifd_pkg::MinFallMs && fdur <= 32'(max_fall_ff)) begin
                     set_hit = 1'b1;
                     mode_in = ifd_pkg::MODE_IMPACT;
                  end else begin
                     mode_in = ifd_pkg::MODE_RECOVERED;
                  end
               end else if (fdur > 32'(max_fall_ff)) begin
                  mode_in = ifd_pkg::MODE_RECOVERED;
               end
            end
            ifd_pkg::MODE_IMPACT: begin
               if (hdur > ifd_pkg::HoldMs) begin
                  mode_in = ifd_pkg::MODE_POST;
                  set_still = 1'b1;
               end
            end
            ifd_pkg::MODE_POST: begin
               if (horiz && still) begin
                  if (sdur > 32'(still_time_ff)) begin
                     mode_in = ifd_pkg::MODE_INJURY;
                     ev_in   = latched_ff;
                  end
               end else if (!still) begin
                  mode_in = ifd_pkg::MODE_RECOVERED;
               end else begin
                  set_still = 1'b1;
               end
            end
            ifd_pkg::MODE_INJURY: ev_in = latched_ff;
            default: begin
               mode_in = ifd_pkg::MODE_NORMAL;
               lat_in  = ifd_pkg::EV_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ifd_pkg::MODE_NORMAL;
         latched_ff    <= ifd_pkg::EV_NONE;
         fall_start_ff <= '0;
         hit_start_ff  <= '0;
         still_start_ff <= '0;
         slot_ff       <= '0;
         for (int i = 0; i < 3; i++) begin
            pmag_ff[i]  <= ifd_pkg::OneG;
            ptime_ff[i] <= '0;
         end
         for (int i = 0; i < ifd_pkg::WindowDepth; i++) win_ff[i] <= ifd_pkg::OneG;
      end else if (cmd.decide) begin
         mode_ff    <= mode_in;
         latched_ff <= lat_in;
         if (set_fall) fall_start_ff <= now_ff;
         if (set_hit) hit_start_ff <= now_ff;
         if (set_still) still_start_ff <= now_ff;
         win_ff[slot_ff] <= mag_ff;
         slot_ff <= (slot_ff == SW'(ifd_pkg::WindowDepth - 1)) ? '0 : slot_ff + 1'b1;
         pmag_ff[2]  <= pmag_ff[1];
         pmag_ff[1]  <= pmag_ff[0];
         pmag_ff[0]  <= mag_ff;
         ptime_ff[2] <= ptime_ff[1];
         ptime_ff[1] <= ptime_ff[0];
         ptime_ff[0] <= now_ff;
         oev_ff    <= ev_in;
         omode_ff  <= mode_in;
         olat_ff   <= lat_in;
         ojerk_ff  <= jerk_ff;
         ohor_ff   <= horiz;
         ostill_ff <= still;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ovalid_ff <= 1'b0;
      else if (cmd.out_load) ovalid_ff <= 1'b1;
      else if (rsp.ready) ovalid_ff <= 1'b0;
   end

   assign rsp.valid         = ovalid_ff;
   assign rsp.event_res     = oev_ff;
   assign rsp.mode          = omode_ff;
   assign rsp.latched_event = olat_ff;
   assign rsp.jerk          = ojerk_ff;
   assign rsp.lying_flat    = ohor_ff;
   assign rsp.is_still      = ostill_ff;

`ifndef ASSERT_OFF
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff < SW'(ifd_pkg::WindowDepth))
      else $error("window slot out of range");
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      omode_ff != 3'd6 && omode_ff != 3'd7 || !ovalid_ff)
      else $error("bad mode code");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without busy");
`endif

endmodule

FILE: rtl/imu_fall_impact_detector.sv
// Top level: fall/impact detector with controller and datapath.
// Sequence: after a sample is accepted, the result word follows three jerk terms, each
// computed as start, 38 restoring steps and add on one shared divider, then a hand-off
// state, a mean step by reciprocal multiply, a decide step and the output load.
// One sample at a time, taken in idle; decide holds while an earlier word waits on ready.
// Synchronous active-high reset: register defaults, mode normal, 1 g history at time 0.
module imu_fall_impact_detector (
   input  logic clock,
   input  logic reset,
   ifd_req_if.sink   req,
   ifd_rsp_if.source rsp,
   ifd_csr_if.sink   csr
);

   ifd_pkg::cmd_type    cmd;
   ifd_pkg::status_type status;
   ifd_req_if           req_int ();
   logic                ready_w;

   assign req_int.valid           = req.valid;
   assign req_int.accel_x         = req.accel_x;
   assign req_int.accel_y         = req.accel_y;
   assign req_int.accel_z         = req.accel_z;
   assign req_int.accel_magnitude = req.accel_magnitude;
   assign req_int.gyro_magnitude  = req.gyro_magnitude;
   assign req_int.time_ms         = req.time_ms;
   assign req.ready               = ready_w;

   ifd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready_w),
      .status    (status),
      .cmd       (cmd)
   );

   ifd_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req_int),
      .rsp    (rsp),
      .csr    (csr),
      .cmd    (cmd),
      .status (status)
   );

endmodule
